// ===== sv/aabb3d_collide_resolve_core_defines.svh =====
// Assertion macros shared by the collision resolve block.
`ifndef AABB3D_COLLIDE_RESOLVE_CORE_DEFINES_SVH
`define AABB3D_COLLIDE_RESOLVE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property check, disabled while in reset
`define A3D_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("aabb3d: property failed");
// Same-cycle implication check
`define A3D_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("aabb3d: implication failed");
`else
`define A3D_ASSERT(lbl, clk, rstn, prop)
`define A3D_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/aabb3d_pkg.sv =====
// Shared constants, codes and control types of the box collision resolve pipeline.
package aabb3d_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int PIPE_DEPTH  = 6;
    localparam int REG_IDX_W   = 3;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SIZE_X   = 3'd0,
        REG_SIZE_Y   = 3'd1,
        REG_SIZE_Z   = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5,
        REG_EXTRUDE  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_Y    = 2'd1,
        CROSS_X    = 2'd2,
        CROSS_Z    = 2'd3
    } cross_t;

    // Per-item control that travels with the coordinates
    typedef struct packed {
        logic       hit;
        logic [2:0] ovl;
        cross_t     axis;
        logic       push_pos;
    } res_ctl_t;

endpackage

// ===== sv/aabb3d_collide_resolve_core.sv =====
// Top level of the 3D box collision test and push-out pipeline.
// Each beat carries one box pair; a new pair is taken every cycle unless a stalled output
// has filled every stage. The six register stages are: offset and face-edge adds, overlap
// and old-side compares, the Y face stage, the X face stage, the Z face stage, and offset
// removal with saturation. Every stage holds its own valid bit and advances whenever it
// is empty or the stage after it advances, so a stalled output holds its beat while empty
// stages upstream keep filling. The user must write registers over the APB port only while
// no beat is in flight; the block itself does not enforce it. There is no state between pairs.
`include "aabb3d_collide_resolve_core_defines.svh"

module aabb3d_collide_resolve_core #(
    parameter int COORD_WIDTH = aabb3d_pkg::COORD_WIDTH,
    localparam int EXT_W    = COORD_WIDTH + 4,
    localparam int DATA_W   = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W   = ADDR_LSB + aabb3d_pkg::REG_IDX_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [ADDR_W-1:0]      paddr,
    input  logic        [DATA_W-1:0]      pwdata,
    output logic        [DATA_W-1:0]      prdata,
    output logic                          pready,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_parent_x,
    input  logic signed [COORD_WIDTH-1:0] s_parent_y,
    input  logic signed [COORD_WIDTH-1:0] s_parent_z,
    input  logic signed [COORD_WIDTH-1:0] s_old_parent_x,
    input  logic signed [COORD_WIDTH-1:0] s_old_parent_y,
    input  logic signed [COORD_WIDTH-1:0] s_old_parent_z,
    input  logic signed [COORD_WIDTH-1:0] s_target_x,
    input  logic signed [COORD_WIDTH-1:0] s_target_y,
    input  logic signed [COORD_WIDTH-1:0] s_target_z,
    input  logic        [COORD_WIDTH-2:0] s_target_size_x,
    input  logic        [COORD_WIDTH-2:0] s_target_size_y,
    input  logic        [COORD_WIDTH-2:0] s_target_size_z,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic        [1:0]             m_crossed_axis,
    output logic                          m_push_positive,
    output logic signed [COORD_WIDTH-1:0] m_new_parent_x,
    output logic signed [COORD_WIDTH-1:0] m_new_parent_y,
    output logic signed [COORD_WIDTH-1:0] m_new_parent_z
);

    localparam int DEPTH = aabb3d_pkg::PIPE_DEPTH;

    // Configuration registers
    logic        [COORD_WIDTH-2:0]             size_reg [3];
    logic        [COORD_WIDTH-1:0]             offset_reg [3];
    logic                                      extrude_reg;
    logic                                      cfg_wr;
    logic        [aabb3d_pkg::REG_IDX_W-1:0]   cfg_idx;
    logic signed [COORD_WIDTH-1:0]             offset_s [3];

    // Pipeline control
    logic        [DEPTH-1:0]                   vld_reg;
    logic        [DEPTH-1:0]                   vld_next;
    logic        [DEPTH:0]                     adv;
    logic        [DEPTH-1:0]                   ld;

    // Input bundles
    logic signed [COORD_WIDTH-1:0]             in_parent [3];
    logic signed [COORD_WIDTH-1:0]             in_old [3];
    logic signed [COORD_WIDTH-1:0]             in_target [3];
    logic        [COORD_WIDTH-2:0]             in_tsize [3];

    // Stage outputs: prep, Y, X, Z
    logic signed [EXT_W-1:0]       p_b [3], lo_b [3], hi_b [3];
    logic signed [EXT_W-1:0]       p_y [3], lo_y [3], hi_y [3];
    logic signed [EXT_W-1:0]       p_x [3], lo_x [3], hi_x [3];
    logic signed [EXT_W-1:0]       p_z [3], lo_z [3], hi_z [3];
    logic        [2:0]             cneg_b, cpos_b, cneg_y, cpos_y;
    logic        [2:0]             cneg_x, cpos_x, cneg_z, cpos_z;
    logic signed [COORD_WIDTH-1:0] par_b [3], par_y [3], par_x [3], par_z [3];
    aabb3d_pkg::res_ctl_t          ctl_b, ctl_y, ctl_x, ctl_z;
    aabb3d_pkg::cross_t            out_axis;
    logic signed [COORD_WIDTH-1:0] out_pos [3];

    // Register write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_LSB +: aabb3d_pkg::REG_IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                size_reg[a]   <= '0;
                offset_reg[a] <= '0;
            end
            extrude_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (aabb3d_pkg::reg_idx_t'(cfg_idx))
                aabb3d_pkg::REG_SIZE_X:   size_reg[aabb3d_pkg::AXIS_X] <= pwdata[COORD_WIDTH-2:0];
                aabb3d_pkg::REG_SIZE_Y:   size_reg[aabb3d_pkg::AXIS_Y] <= pwdata[COORD_WIDTH-2:0];
                aabb3d_pkg::REG_SIZE_Z:   size_reg[aabb3d_pkg::AXIS_Z] <= pwdata[COORD_WIDTH-2:0];
                aabb3d_pkg::REG_OFFSET_X: offset_reg[aabb3d_pkg::AXIS_X] <= pwdata[COORD_WIDTH-1:0];
                aabb3d_pkg::REG_OFFSET_Y: offset_reg[aabb3d_pkg::AXIS_Y] <= pwdata[COORD_WIDTH-1:0];
                aabb3d_pkg::REG_OFFSET_Z: offset_reg[aabb3d_pkg::AXIS_Z] <= pwdata[COORD_WIDTH-1:0];
                aabb3d_pkg::REG_EXTRUDE:  extrude_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (aabb3d_pkg::reg_idx_t'(cfg_idx))
            aabb3d_pkg::REG_SIZE_X:   prdata = DATA_W'(size_reg[aabb3d_pkg::AXIS_X]);
            aabb3d_pkg::REG_SIZE_Y:   prdata = DATA_W'(size_reg[aabb3d_pkg::AXIS_Y]);
            aabb3d_pkg::REG_SIZE_Z:   prdata = DATA_W'(size_reg[aabb3d_pkg::AXIS_Z]);
            aabb3d_pkg::REG_OFFSET_X: prdata = DATA_W'(offset_reg[aabb3d_pkg::AXIS_X]);
            aabb3d_pkg::REG_OFFSET_Y: prdata = DATA_W'(offset_reg[aabb3d_pkg::AXIS_Y]);
            aabb3d_pkg::REG_OFFSET_Z: prdata = DATA_W'(offset_reg[aabb3d_pkg::AXIS_Z]);
            aabb3d_pkg::REG_EXTRUDE:  prdata = DATA_W'(extrude_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            offset_s[a] = $signed(offset_reg[a]);
        end
    end

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        adv[DEPTH] = m_ready;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        ld[0]       = adv[0] && s_valid;
        for (int k = 1; k < DEPTH; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
            ld[k]       = adv[k] && vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[DEPTH-1];

    // Gather input beat per axis
    assign in_parent[aabb3d_pkg::AXIS_X] = s_parent_x;
    assign in_parent[aabb3d_pkg::AXIS_Y] = s_parent_y;
    assign in_parent[aabb3d_pkg::AXIS_Z] = s_parent_z;
    assign in_old[aabb3d_pkg::AXIS_X]    = s_old_parent_x;
    assign in_old[aabb3d_pkg::AXIS_Y]    = s_old_parent_y;
    assign in_old[aabb3d_pkg::AXIS_Z]    = s_old_parent_z;
    assign in_target[aabb3d_pkg::AXIS_X] = s_target_x;
    assign in_target[aabb3d_pkg::AXIS_Y] = s_target_y;
    assign in_target[aabb3d_pkg::AXIS_Z] = s_target_z;
    assign in_tsize[aabb3d_pkg::AXIS_X]  = s_target_size_x;
    assign in_tsize[aabb3d_pkg::AXIS_Y]  = s_target_size_y;
    assign in_tsize[aabb3d_pkg::AXIS_Z]  = s_target_size_z;

    aabb3d_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
        .aclk        (aclk),
        .ld_a        (ld[0]),
        .ld_b        (ld[1]),
        .parent      (in_parent),
        .old_parent  (in_old),
        .target      (in_target),
        .target_size (in_tsize),
        .own_size    (size_reg),
        .own_offset  (offset_s),
        .p_out       (p_b),
        .lo_out      (lo_b),
        .hi_out      (hi_b),
        .cneg_out    (cneg_b),
        .cpos_out    (cpos_b),
        .parent_out  (par_b),
        .ctl_out     (ctl_b)
    );

    // Resolve order: Y, then X, then Z
    aabb3d_face #(
        .COORD_WIDTH (COORD_WIDTH),
        .AXIS        (aabb3d_pkg::AXIS_Y),
        .CODE        (aabb3d_pkg::CROSS_Y)
    ) u_face_y (
        .aclk       (aclk),
        .ld         (ld[2]),
        .extrude    (extrude_reg),
        .p_in       (p_b),
        .lo_in      (lo_b),
        .hi_in      (hi_b),
        .cneg_in    (cneg_b),
        .cpos_in    (cpos_b),
        .parent_in  (par_b),
        .ctl_in     (ctl_b),
        .p_out      (p_y),
        .lo_out     (lo_y),
        .hi_out     (hi_y),
        .cneg_out   (cneg_y),
        .cpos_out   (cpos_y),
        .parent_out (par_y),
        .ctl_out    (ctl_y)
    );

    aabb3d_face #(
        .COORD_WIDTH (COORD_WIDTH),
        .AXIS        (aabb3d_pkg::AXIS_X),
        .CODE        (aabb3d_pkg::CROSS_X)
    ) u_face_x (
        .aclk       (aclk),
        .ld         (ld[3]),
        .extrude    (extrude_reg),
        .p_in       (p_y),
        .lo_in      (lo_y),
        .hi_in      (hi_y),
        .cneg_in    (cneg_y),
        .cpos_in    (cpos_y),
        .parent_in  (par_y),
        .ctl_in     (ctl_y),
        .p_out      (p_x),
        .lo_out     (lo_x),
        .hi_out     (hi_x),
        .cneg_out   (cneg_x),
        .cpos_out   (cpos_x),
        .parent_out (par_x),
        .ctl_out    (ctl_x)
    );

    aabb3d_face #(
        .COORD_WIDTH (COORD_WIDTH),
        .AXIS        (aabb3d_pkg::AXIS_Z),
        .CODE        (aabb3d_pkg::CROSS_Z)
    ) u_face_z (
        .aclk       (aclk),
        .ld         (ld[4]),
        .extrude    (extrude_reg),
        .p_in       (p_x),
        .lo_in      (lo_x),
        .hi_in      (hi_x),
        .cneg_in    (cneg_x),
        .cpos_in    (cpos_x),
        .parent_in  (par_x),
        .ctl_in     (ctl_x),
        .p_out      (p_z),
        .lo_out     (lo_z),
        .hi_out     (hi_z),
        .cneg_out   (cneg_z),
        .cpos_out   (cpos_z),
        .parent_out (par_z),
        .ctl_out    (ctl_z)
    );

    aabb3d_out #(.COORD_WIDTH(COORD_WIDTH)) u_out (
        .aclk          (aclk),
        .ld            (ld[5]),
        .p_in          (p_z),
        .parent_in     (par_z),
        .own_offset    (offset_s),
        .ctl_in        (ctl_z),
        .hit           (m_hit),
        .crossed_axis  (out_axis),
        .push_positive (m_push_positive),
        .new_parent    (out_pos)
    );

    assign m_crossed_axis = out_axis;
    assign m_new_parent_x = out_pos[aabb3d_pkg::AXIS_X];
    assign m_new_parent_y = out_pos[aabb3d_pkg::AXIS_Y];
    assign m_new_parent_z = out_pos[aabb3d_pkg::AXIS_Z];

    // An empty first stage always takes a beat
    `A3D_ASSERT_IMPL(a_first_stage_free, aclk, aresetn, !vld_reg[0], s_ready)
    // Beats in flight change only by accepted input and output beats
    `A3D_ASSERT(a_beat_count, aclk, aresetn, $past(aresetn) |-> ($countones(vld_reg) == $countones($past(vld_reg)) + $past(s_valid && s_ready) - $past(m_valid && m_ready)))
    // A negative-side push needs extrusion and a recorded crossing
    `A3D_ASSERT_IMPL(a_push_side, aclk, aresetn, m_valid && !m_push_positive, extrude_reg && (out_axis != aabb3d_pkg::CROSS_NONE))

endmodule

// ===== sv/aabb3d_prep.sv =====
// Front stages: offset the positions, build face edges, then test overlap and old side.
module aabb3d_prep #(
    parameter int COORD_WIDTH = aabb3d_pkg::COORD_WIDTH,
    localparam int EXT_W = COORD_WIDTH + 4
) (
    input  logic                          aclk,
    input  logic                          ld_a,
    input  logic                          ld_b,
    input  logic signed [COORD_WIDTH-1:0] parent [3],
    input  logic signed [COORD_WIDTH-1:0] old_parent [3],
    input  logic signed [COORD_WIDTH-1:0] target [3],
    input  logic        [COORD_WIDTH-2:0] target_size [3],
    input  logic        [COORD_WIDTH-2:0] own_size [3],
    input  logic signed [COORD_WIDTH-1:0] own_offset [3],
    output logic signed [EXT_W-1:0]       p_out [3],
    output logic signed [EXT_W-1:0]       lo_out [3],
    output logic signed [EXT_W-1:0]       hi_out [3],
    output logic        [2:0]             cneg_out,
    output logic        [2:0]             cpos_out,
    output logic signed [COORD_WIDTH-1:0] parent_out [3],
    output aabb3d_pkg::res_ctl_t          ctl_out
);

    localparam int PAD_W = EXT_W - COORD_WIDTH;

    logic signed [EXT_W-1:0]       pa_next [3];
    logic signed [EXT_W-1:0]       oa_next [3];
    logic signed [EXT_W-1:0]       loa_next [3];
    logic signed [EXT_W-1:0]       hia_next [3];
    logic signed [EXT_W-1:0]       pa_reg [3];
    logic signed [EXT_W-1:0]       oa_reg [3];
    logic signed [EXT_W-1:0]       loa_reg [3];
    logic signed [EXT_W-1:0]       hia_reg [3];
    logic signed [COORD_WIDTH-1:0] para_reg [3];

    logic        [2:0]             cneg_next;
    logic        [2:0]             cpos_next;
    aabb3d_pkg::res_ctl_t          ctl_next;
    logic signed [EXT_W-1:0]       pb_reg [3];
    logic signed [EXT_W-1:0]       lob_reg [3];
    logic signed [EXT_W-1:0]       hib_reg [3];
    logic        [2:0]             cneg_reg;
    logic        [2:0]             cpos_reg;
    logic signed [COORD_WIDTH-1:0] parb_reg [3];
    aabb3d_pkg::res_ctl_t          ctl_reg;

    // Centre positions and the two face edges widened by the own half size
    always_comb begin
        logic signed [EXT_W-1:0] off_e;
        logic signed [EXT_W-1:0] t_e;
        logic signed [EXT_W-1:0] h_e;
        logic signed [EXT_W-1:0] th_e;
        for (int a = 0; a < 3; a++) begin
            off_e = {{PAD_W{own_offset[a][COORD_WIDTH-1]}}, own_offset[a]};
            t_e   = {{PAD_W{target[a][COORD_WIDTH-1]}}, target[a]};
            h_e   = $signed({{(PAD_W+2){1'b0}}, own_size[a][COORD_WIDTH-2:1]});
            th_e  = $signed({{(PAD_W+2){1'b0}}, target_size[a][COORD_WIDTH-2:1]});
            pa_next[a]  = {{PAD_W{parent[a][COORD_WIDTH-1]}}, parent[a]} + off_e;
            oa_next[a]  = {{PAD_W{old_parent[a][COORD_WIDTH-1]}}, old_parent[a]} + off_e;
            loa_next[a] = t_e - th_e - h_e;
            hia_next[a] = t_e + th_e + h_e;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            pa_reg   <= pa_next;
            oa_reg   <= oa_next;
            loa_reg  <= loa_next;
            hia_reg  <= hia_next;
            para_reg <= parent;
        end
    end

    // Overlap per axis and which side the old position stood on
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cneg_next[a]    = oa_reg[a] <= loa_reg[a];
            cpos_next[a]    = oa_reg[a] >= hia_reg[a];
            ctl_next.ovl[a] = (pa_reg[a] > loa_reg[a]) && (pa_reg[a] < hia_reg[a]);
        end
        ctl_next.hit      = &ctl_next.ovl;
        ctl_next.axis     = aabb3d_pkg::CROSS_NONE;
        ctl_next.push_pos = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (ld_b) begin
            pb_reg   <= pa_reg;
            lob_reg  <= loa_reg;
            hib_reg  <= hia_reg;
            cneg_reg <= cneg_next;
            cpos_reg <= cpos_next;
            parb_reg <= para_reg;
            ctl_reg  <= ctl_next;
        end
    end

    assign p_out      = pb_reg;
    assign lo_out     = lob_reg;
    assign hi_out     = hib_reg;
    assign cneg_out   = cneg_reg;
    assign cpos_out   = cpos_reg;
    assign parent_out = parb_reg;
    assign ctl_out    = ctl_reg;

endmodule

// ===== sv/aabb3d_face.sv =====
// One resolve stage: face crossing test and push-out along a single axis.
module aabb3d_face #(
    parameter int COORD_WIDTH = aabb3d_pkg::COORD_WIDTH,
    parameter int AXIS = aabb3d_pkg::AXIS_Y,
    parameter aabb3d_pkg::cross_t CODE = aabb3d_pkg::CROSS_Y,
    localparam int EXT_W = COORD_WIDTH + 4
) (
    input  logic                          aclk,
    input  logic                          ld,
    input  logic                          extrude,
    input  logic signed [EXT_W-1:0]       p_in [3],
    input  logic signed [EXT_W-1:0]       lo_in [3],
    input  logic signed [EXT_W-1:0]       hi_in [3],
    input  logic        [2:0]             cneg_in,
    input  logic        [2:0]             cpos_in,
    input  logic signed [COORD_WIDTH-1:0] parent_in [3],
    input  aabb3d_pkg::res_ctl_t          ctl_in,
    output logic signed [EXT_W-1:0]       p_out [3],
    output logic signed [EXT_W-1:0]       lo_out [3],
    output logic signed [EXT_W-1:0]       hi_out [3],
    output logic        [2:0]             cneg_out,
    output logic        [2:0]             cpos_out,
    output logic signed [COORD_WIDTH-1:0] parent_out [3],
    output aabb3d_pkg::res_ctl_t          ctl_out
);

    localparam int OTHER_A = (AXIS + 1) % 3;
    localparam int OTHER_B = (AXIS + 2) % 3;

    logic signed [EXT_W-1:0]       p_next [3];
    aabb3d_pkg::res_ctl_t          ctl_next;
    logic signed [EXT_W-1:0]       p_reg [3];
    logic signed [EXT_W-1:0]       lo_reg [3];
    logic signed [EXT_W-1:0]       hi_reg [3];
    logic        [2:0]             cneg_reg;
    logic        [2:0]             cpos_reg;
    logic signed [COORD_WIDTH-1:0] parent_reg [3];
    aabb3d_pkg::res_ctl_t          ctl_reg;

    // Low face first, then the high face on the possibly pushed position
    always_comb begin
        logic                    en;
        logic                    hit_lo;
        logic                    hit_hi;
        logic signed [EXT_W-1:0] p_mid;
        logic signed [EXT_W-1:0] p_fin;
        en     = ctl_in.ovl[OTHER_A] && ctl_in.ovl[OTHER_B];
        hit_lo = en && cneg_in[AXIS] && (p_in[AXIS] > lo_in[AXIS]);
        p_mid  = (hit_lo && extrude) ? lo_in[AXIS] : p_in[AXIS];
        hit_hi = en && cpos_in[AXIS] && (p_mid < hi_in[AXIS]);
        p_fin  = (hit_hi && extrude) ? hi_in[AXIS] : p_mid;

        p_next       = p_in;
        p_next[AXIS] = p_fin;
        ctl_next     = ctl_in;
        if (hit_lo || hit_hi) begin
            ctl_next.axis = CODE;
        end
        if (hit_lo && extrude) begin
            ctl_next.push_pos = 1'b0;
        end
        // Refresh overlap of this axis for the later stages
        ctl_next.ovl[AXIS] = (p_fin > lo_in[AXIS]) && (p_fin < hi_in[AXIS]);
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            p_reg      <= p_next;
            lo_reg     <= lo_in;
            hi_reg     <= hi_in;
            cneg_reg   <= cneg_in;
            cpos_reg   <= cpos_in;
            parent_reg <= parent_in;
            ctl_reg    <= ctl_next;
        end
    end

    assign p_out      = p_reg;
    assign lo_out     = lo_reg;
    assign hi_out     = hi_reg;
    assign cneg_out   = cneg_reg;
    assign cpos_out   = cpos_reg;
    assign parent_out = parent_reg;
    assign ctl_out    = ctl_reg;

endmodule

// ===== sv/aabb3d_out.sv =====
// Output stage: remove the offset, saturate, and pick resolved or input position.
module aabb3d_out #(
    parameter int COORD_WIDTH = aabb3d_pkg::COORD_WIDTH,
    localparam int EXT_W = COORD_WIDTH + 4
) (
    input  logic                          aclk,
    input  logic                          ld,
    input  logic signed [EXT_W-1:0]       p_in [3],
    input  logic signed [COORD_WIDTH-1:0] parent_in [3],
    input  logic signed [COORD_WIDTH-1:0] own_offset [3],
    input  aabb3d_pkg::res_ctl_t          ctl_in,
    output logic                          hit,
    output aabb3d_pkg::cross_t            crossed_axis,
    output logic                          push_positive,
    output logic signed [COORD_WIDTH-1:0] new_parent [3]
);

    localparam int PAD_W = EXT_W - COORD_WIDTH;
    localparam logic signed [EXT_W-1:0] SAT_MAX =
        $signed({{(PAD_W+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [COORD_WIDTH-1:0] pos_next [3];
    logic signed [COORD_WIDTH-1:0] pos_reg [3];
    logic                          hit_reg;
    aabb3d_pkg::cross_t            axis_reg;
    logic                          push_reg;

    // Back to parent frame, clamp to the coordinate range
    always_comb begin
        logic signed [EXT_W-1:0] diff;
        for (int a = 0; a < 3; a++) begin
            diff = p_in[a] - {{PAD_W{own_offset[a][COORD_WIDTH-1]}}, own_offset[a]};
            if (!ctl_in.hit) begin
                pos_next[a] = parent_in[a];
            end else if (diff > SAT_MAX) begin
                pos_next[a] = SAT_MAX[COORD_WIDTH-1:0];
            end else if (diff < SAT_MIN) begin
                pos_next[a] = SAT_MIN[COORD_WIDTH-1:0];
            end else begin
                pos_next[a] = diff[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            pos_reg  <= pos_next;
            hit_reg  <= ctl_in.hit;
            axis_reg <= ctl_in.axis;
            push_reg <= ctl_in.push_pos;
        end
    end

    assign hit           = hit_reg;
    assign crossed_axis  = axis_reg;
    assign push_positive = push_reg;
    assign new_parent    = pos_reg;

endmodule
